// ===== sv/mtpg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtpg_pkg
// Shared types, codes and helpers for the match timer PWM generator.
// ----------------------------------------------------------------------------
package mtpg_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 32;
  localparam int unsigned CHANNELS_DEF      = 3;

  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned PRESC_W   = 16;
  localparam int unsigned MASK_W    = 3;
  localparam int unsigned DUTY_W    = 10;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [DUTY_W-1:0] PERMILLE_FULL = 10'd1000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_START  = 3'd1,
    FUNC_STOP   = 3'd2,
    FUNC_DUTY   = 3'd3,
    FUNC_PERIOD = 3'd4
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERMILLE = 8'd3;

  // off-time fraction in per-mille, duty saturated at full scale
  function automatic logic [DUTY_W-1:0] duty_comp(input logic [VALUE_W-1:0] duty);
    logic [DUTY_W-1:0] d;
    d = (duty > VALUE_W'(PERMILLE_FULL)) ? PERMILLE_FULL : duty[DUTY_W-1:0];
    return PERMILLE_FULL - d;
  endfunction

endpackage

// ===== sv/mtpg_in_stage.sv =====
// ----------------------------------------------------------------------------
// mtpg_in_stage
// Input register and match product multiplier (period times off-fraction).
// ----------------------------------------------------------------------------
module mtpg_in_stage #(
  parameter int unsigned COUNTER_WIDTH = mtpg_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mtpg_pkg::FUNC_W-1:0]       in_func,
  input  logic [mtpg_pkg::VALUE_W-1:0]      in_value,
  input  logic                              take,
  input  logic [COUNTER_WIDTH-1:0]          mul_a,
  input  logic [mtpg_pkg::DUTY_W-1:0]       mul_b,
  output logic [COUNTER_WIDTH+mtpg_pkg::DUTY_W-1:0] mul_p,
  output logic                              s1_valid,
  output logic [mtpg_pkg::FUNC_W-1:0]       s1_func,
  output logic [mtpg_pkg::VALUE_W-1:0]      s1_value,
  output logic [COUNTER_WIDTH+mtpg_pkg::DUTY_W-1:0] s1_prod
);
  import mtpg_pkg::*;

  localparam int unsigned PW = COUNTER_WIDTH + DUTY_W;

  logic                s1_valid_r, s1_valid_nxt;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [VALUE_W-1:0]  s1_value_r;
  logic [PW-1:0]       s1_prod_r;
  logic                load;

  assign mul_p    = PW'(mul_a) * PW'(mul_b);
  assign in_stall = s1_valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_func_r  <= in_func;
      s1_value_r <= in_value;
      s1_prod_r  <= mul_p;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_func  = s1_func_r;
  assign s1_value = s1_value_r;
  assign s1_prod  = s1_prod_r;

endmodule

// ===== sv/mtpg_core.sv =====
// ----------------------------------------------------------------------------
// mtpg_core
// Timer state, configuration registers and the result register.
// ----------------------------------------------------------------------------
module mtpg_core #(
  parameter int unsigned COUNTER_WIDTH = mtpg_pkg::COUNTER_WIDTH_DEF,
  parameter int unsigned CHANNELS      = mtpg_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mtpg_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic [mtpg_pkg::VALUE_W-1:0]      in_value,
  input  logic                              s1_valid,
  input  logic [mtpg_pkg::FUNC_W-1:0]       s1_func,
  input  logic [mtpg_pkg::VALUE_W-1:0]      s1_value,
  input  logic [COUNTER_WIDTH+mtpg_pkg::DUTY_W-1:0] s1_prod,
  input  logic [COUNTER_WIDTH+mtpg_pkg::DUTY_W-1:0] mul_p,
  output logic                              take,
  output logic [COUNTER_WIDTH-1:0]          mul_a,
  output logic [mtpg_pkg::DUTY_W-1:0]       mul_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mtpg_pkg::MASK_W-1:0]       out_pwm_out,
  output logic                              out_running,
  output logic                              out_stop_event,
  output logic [mtpg_pkg::VALUE_W-1:0]      out_count_now
);
  import mtpg_pkg::*;

  localparam int unsigned W  = COUNTER_WIDTH;
  localparam int unsigned SW = COUNTER_WIDTH + DUTY_W;
  localparam logic [SW-1:0] SCALE_STEP = SW'(PERMILLE_FULL);
  localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((1 << CHANNELS) - 1);

  // configuration registers
  logic [PRESC_W-1:0]   divider_r;
  logic [MASK_W-1:0]    mask_r;
  logic [VALUE_W-1:0]   init_period_r;
  logic [DUTY_W-1:0]    init_permille_r;

  // timer state; scaled_r tracks 1000*(count+1), match_r holds period*(1000-duty)
  logic [PRESC_W-1:0]   presc_r,   presc_nxt;
  logic [W-1:0]         count_r,   count_nxt;
  logic [SW-1:0]        scaled_r,  scaled_nxt;
  logic [W-1:0]         period_r,  period_nxt;
  logic [SW-1:0]        match_r,   match_nxt;
  logic                 run_r,     run_nxt;
  logic                 pend_r,    pend_nxt;
  logic                 stop_ev;

  logic                 out_valid_r;
  logic [MASK_W-1:0]    pwm_r;
  logic                 running_r;
  logic                 stop_ev_r;
  logic [VALUE_W-1:0]   count_now_r;

  logic                 cfg_we;
  logic                 cfg_setup;
  logic                 process;
  logic [PRESC_W-1:0]   div_eff;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign cfg_setup = cfg_we && (cfg_index == CFG_PERIOD || cfg_index == CFG_PERMILLE);
  assign take      = !out_valid_r || !out_stall;
  assign process   = s1_valid && take;
  assign div_eff   = (divider_r == '0) ? PRESC_W'(1) : divider_r;

  // period after this cycle also feeds the product for the next accepted item
  always_comb begin
    period_nxt = period_r;
    if (cfg_we && cfg_index == CFG_PERIOD) begin
      period_nxt = cfg_data[W-1:0];
    end else if (cfg_we && cfg_index == CFG_PERMILLE) begin
      period_nxt = init_period_r[W-1:0];
    end else if (process && s1_func == FUNC_PERIOD) begin
      period_nxt = s1_value[W-1:0];
    end
  end

  assign mul_a = period_nxt;

  always_comb begin
    if (cfg_we && cfg_index == CFG_PERIOD) begin
      mul_b = duty_comp(VALUE_W'(init_permille_r));
    end else if (cfg_we && cfg_index == CFG_PERMILLE) begin
      mul_b = duty_comp(VALUE_W'(cfg_data[DUTY_W-1:0]));
    end else begin
      mul_b = duty_comp(in_value);
    end
  end

  always_comb begin
    presc_nxt  = presc_r;
    count_nxt  = count_r;
    scaled_nxt = scaled_r;
    match_nxt  = match_r;
    run_nxt    = run_r;
    pend_nxt   = pend_r;
    stop_ev    = 1'b0;
    if (cfg_setup) begin
      match_nxt = mul_p;
    end
    if (process) begin
      case (func_t'(s1_func))
        FUNC_TICK: begin
          if (run_r) begin
            if ({1'b0, presc_r} + 17'd1 >= {1'b0, div_eff}) begin
              presc_nxt = '0;
              if (count_r >= period_r) begin
                count_nxt  = '0;
                scaled_nxt = SCALE_STEP;
                if (pend_r) begin
                  pend_nxt = 1'b0;
                  run_nxt  = 1'b0;
                  stop_ev  = 1'b1;
                end
              end else begin
                count_nxt  = count_r + W'(1);
                scaled_nxt = scaled_r + SCALE_STEP;
              end
            end else begin
              presc_nxt = presc_r + PRESC_W'(1);
            end
          end
        end
        FUNC_START: begin
          run_nxt = 1'b1;
        end
        FUNC_STOP: begin
          if (run_r) begin
            pend_nxt = 1'b1;
          end
        end
        FUNC_DUTY: begin
          match_nxt = s1_prod;
        end
        FUNC_PERIOD: begin
          count_nxt  = '0;
          scaled_nxt = SCALE_STEP;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r       <= '0;
      mask_r          <= '0;
      init_period_r   <= '0;
      init_permille_r <= '0;
      presc_r         <= '0;
      count_r         <= '0;
      scaled_r        <= SCALE_STEP;
      period_r        <= '0;
      match_r         <= '0;
      run_r           <= 1'b0;
      pend_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRESCALE: divider_r       <= cfg_data[PRESC_W-1:0];
          CFG_MASK:     mask_r          <= cfg_data[MASK_W-1:0];
          CFG_PERIOD:   init_period_r   <= cfg_data;
          CFG_PERMILLE: init_permille_r <= cfg_data[DUTY_W-1:0];
          default: begin
          end
        endcase
      end
      presc_r  <= presc_nxt;
      count_r  <= count_nxt;
      scaled_r <= scaled_nxt;
      period_r <= period_nxt;
      match_r  <= match_nxt;
      run_r    <= run_nxt;
      pend_r   <= pend_nxt;
      if (take) begin
        out_valid_r <= process;
      end
    end
  end

  // count >= floor(prod/1000) holds exactly when prod < 1000*(count+1)
  always_ff @(posedge clk) begin
    if (process) begin
      pwm_r       <= (run_nxt && (match_nxt < scaled_nxt)) ? (mask_r & CH_MASK) : '0;
      running_r   <= run_nxt;
      stop_ev_r   <= stop_ev;
      count_now_r <= VALUE_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pwm_out    = pwm_r;
  assign out_running    = running_r;
  assign out_stop_event = stop_ev_r;
  assign out_count_now  = count_now_r;

endmodule

// ===== sv/match_timer_pwm_generator.sv =====
// ----------------------------------------------------------------------------
// match_timer_pwm_generator
// Three-channel match timer with per-mille duty and deferred stop.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transaction per command (tick, start, request stop, set duty,
//            set period) with its value; accepted when in_valid and !in_stall.
//   out_*  : one transaction per command with channel levels, run flag, stop
//            event and the counter value after that command.
//   cfg_*  : register writes (prescale divider, channel mask, initial period,
//            initial duty); cfg_ready is always high, write only while idle.
// From input acceptance a transaction passes the input register, where the
// duty product is formed by one COUNTER_WIDTH x 10 multiplier, and then the
// timer update into the result register. Throughput is one transaction per
// cycle while the receiver does not stall.
// The match compare avoids the divide by 1000 by comparing the stored product
// against a register that tracks 1000*(count+1).
// Reset (rst_n low, synchronous) clears configuration, timer state and valid
// flags, stops the timer and empties both stages. If the receiver stalls, the
// result holds; once the input register is also full, in_stall goes high.
// ----------------------------------------------------------------------------
module match_timer_pwm_generator #(
  parameter int unsigned COUNTER_WIDTH = mtpg_pkg::COUNTER_WIDTH_DEF,
  parameter int unsigned CHANNELS      = mtpg_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mtpg_pkg::FUNC_W-1:0]    in_func,
  input  logic [mtpg_pkg::VALUE_W-1:0]   in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mtpg_pkg::MASK_W-1:0]    out_pwm_out,
  output logic                           out_running,
  output logic                           out_stop_event,
  output logic [mtpg_pkg::VALUE_W-1:0]   out_count_now,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mtpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtpg_pkg::CFG_DAT_W-1:0] cfg_data
);
  import mtpg_pkg::*;

  localparam int unsigned PW = COUNTER_WIDTH + DUTY_W;

  logic                     take;
  logic [COUNTER_WIDTH-1:0] mul_a;
  logic [DUTY_W-1:0]        mul_b;
  logic [PW-1:0]            mul_p;
  logic                     s1_valid;
  logic [FUNC_W-1:0]        s1_func;
  logic [VALUE_W-1:0]       s1_value;
  logic [PW-1:0]            s1_prod;

  mtpg_in_stage #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .in_value (in_value),
    .take     (take),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .mul_p    (mul_p),
    .s1_valid (s1_valid),
    .s1_func  (s1_func),
    .s1_value (s1_value),
    .s1_prod  (s1_prod)
  );

  mtpg_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .CHANNELS      (CHANNELS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_value       (in_value),
    .s1_valid       (s1_valid),
    .s1_func        (s1_func),
    .s1_value       (s1_value),
    .s1_prod        (s1_prod),
    .mul_p          (mul_p),
    .take           (take),
    .mul_a          (mul_a),
    .mul_b          (mul_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pwm_out    (out_pwm_out),
    .out_running    (out_running),
    .out_stop_event (out_stop_event),
    .out_count_now  (out_count_now)
  );

endmodule
